// ===== rtl/batrt_pkg.sv =====
// Package for the BLE address table RSSI tracker: constants, codes, the 2^f table.
// No dependencies.
package batrt_pkg;
	localparam int TableDepth = 20;
	localparam int ExpDepth = 64;
	localparam int IdxW = 5;
	localparam int ExpIdxW = 6;
	localparam int EntryW = 48 + 8 + 32 + 1;

	localparam logic [2:0] CMD_ADVERT = 3'd0;
	localparam logic [2:0] CMD_CLEAR = 3'd1;
	localparam logic [2:0] CMD_LOCK = 3'd2;
	localparam logic [2:0] CMD_RELEASE = 3'd3;
	localparam logic [2:0] CMD_TICK = 3'd4;
	localparam logic [2:0] CMD_READ = 3'd5;

	localparam logic [3:0] ST_UPDATED = 4'd0;
	localparam logic [3:0] ST_ADDED = 4'd1;
	localparam logic [3:0] ST_FULL = 4'd2;
	localparam logic [3:0] ST_LOCK_RSSI = 4'd3;
	localparam logic [3:0] ST_IGNORED = 4'd4;
	localparam logic [3:0] ST_CLEARED = 4'd5;
	localparam logic [3:0] ST_LOCKED = 4'd6;
	localparam logic [3:0] ST_LOCK_REJ = 4'd7;
	localparam logic [3:0] ST_RELEASED = 4'd8;
	localparam logic [3:0] ST_FILTERED = 4'd9;
	localparam logic [3:0] ST_READ_OK = 4'd10;
	localparam logic [3:0] ST_READ_OOR = 4'd11;

	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_REF = 2'd1;
	localparam logic [1:0] REG_SCALE = 2'd2;

	localparam logic signed [15:0] SMOOTH_RESET = -16'sd25600;
	localparam logic [63:0] LN2_Q32 = 64'd2977044472;

	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_WAIT, S_EMA, S_DIST1, S_DIST2, S_DIST3, S_OUT
	} state_t;

	typedef logic [ExpDepth-1:0][33:0] exp_tab_t;

	// 2^(i/ExpDepth) in Q32, Taylor series of exp.
	function automatic logic [33:0] exp2_entry(input logic [ExpIdxW-1:0] idx);
		logic [63:0] x;
		logic [63:0] sum;
		logic [63:0] term;
		logic done;
		x = (64'(idx) * LN2_Q32) / ExpDepth;
		sum = 64'd1 << 32;
		term = 64'd1 << 32;
		done = 1'b0;
		for (int n = 1; n < 40; n++) begin
			if (!done) begin
				term = ((term * x) >> 32) / 64'(n);
				if (term == 64'd0) done = 1'b1;
				else sum = sum + term;
			end
		end
		return sum[33:0];
	endfunction

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		for (int i = 0; i < ExpDepth; i++) tab[i] = exp2_entry(ExpIdxW'(i));
		return tab;
	endfunction

	// The whole table is built at elaboration and becomes a constant lookup.
	localparam exp_tab_t EXP2_TAB = build_exp_tab();
endpackage

// ===== rtl/batrt_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module batrt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== rtl/ble_address_table_rssi_tracker.sv =====
// Top level of the BLE address table RSSI tracker.
// Depends on batrt_pkg and batrt_ram.
//
// Usage: raise start with cmd and its fields while busy is low; that edge is the
// transfer of one command. busy stays high until the result appears: done is
// high for exactly one cycle with status and the other result ports valid.
// The receiver cannot stall; a result is shown once and must be taken then.
// An advert in scan mode walks the table one entry per cycle through
// the single RAM read port, and done rises once a match is found or the
// walk reaches the count. An advert in lock mode and the other commands pass
// through S_WAIT (a tick also through S_EMA) and the distance stages to done.
// One command is in flight at a time; the next may be transferred while done is high.
// The distance runs through one 17x16 multiply, one lookup in a constant 2^f
// table and a multiply by 100, each registered. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect at once and belong to idle periods.
// Reset clears mode, count and target address, sets target level and smoothed
// value to -100 dBm and loads the register defaults; the table RAM is not
// cleared, since only entries below the count are ever read.
module ble_address_table_rssi_tracker (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] cmd,
	input logic [47:0] dev_addr,
	input logic signed [7:0] sig_dbm,
	input logic has_name,
	input logic [31:0] now_ms,
	input logic [4:0] entry_sel,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	output logic done,
	output logic [3:0] status,
	output logic mode_now,
	output logic [4:0] entry_count,
	output logic [4:0] entry_pos,
	output logic [47:0] entry_addr,
	output logic signed [7:0] entry_dbm,
	output logic [31:0] entry_seen_ms,
	output logic entry_named,
	output logic signed [15:0] smooth_q8,
	output logic [15:0] distance_cm
);
	import batrt_pkg::*;

	state_t state_q, state_d;

	logic [8:0] alpha_q;
	logic signed [7:0] ref_q;
	logic [15:0] scale_q;
	logic lock_q;
	logic [IdxW-1:0] count_q;
	logic [47:0] taddr_q;
	logic signed [7:0] tdbm_q;
	logic signed [15:0] smooth_q;

	logic [2:0] cmd_q;
	logic [47:0] addr_q;
	logic signed [7:0] sig_q;
	logic name_q;
	logic [31:0] now_q;
	logic [IdxW-1:0] ptr_q;
	logic [3:0] status_q;
	logic [IdxW-1:0] pos_q;
	logic rd_pending_q;

	// RAM port.
	logic ram_we;
	logic [IdxW-1:0] ram_addr;
	logic [EntryW-1:0] ram_wdata, ram_rdata;
	logic [47:0] rd_addr;
	logic signed [7:0] rd_dbm;
	logic [31:0] rd_seen;
	logic rd_named;

	assign {rd_addr, rd_dbm, rd_seen, rd_named} = ram_rdata;

	batrt_ram #(.Width(EntryW), .Depth(TableDepth)) u_table (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// Distance pipeline registers.
	logic signed [40:0] t_s1;
	logic [33:0] ent_s2;
	logic signed [16:0] k_s2;
	logic [40:0] val_s3;
	logic signed [16:0] k_s3;

	logic signed [16:0] diff;
	logic [8:0] a_sat;
	logic signed [25:0] ema_acc;
	logic signed [16:0] kf;
	logic [ExpIdxW-1:0] eidx;
	logic [15:0] dist_est;
	logic [5:0] shamt;
	logic [40:0] rnd;

	assign diff = 17'(ref_q) * 17'sd256 - 17'(smooth_q);
	assign a_sat = (alpha_q > 9'd256) ? 9'd256 : alpha_q;
	assign ema_acc = $signed({1'b0, a_sat}) * 26'(tdbm_q) * 26'sd256
		+ $signed(10'sd256 - $signed({1'b0, a_sat})) * 26'(smooth_q) + 26'sd128;
	assign kf = 17'(t_s1 >>> 24);
	assign eidx = t_s1[23:18];

	always_comb begin
		shamt = 6'd0;
		rnd = '0;
		dist_est = 16'd0;
		if (!lock_q) dist_est = 16'd0;
		else if (k_s3 > 17'sd16) dist_est = 16'hFFFF;
		else if (k_s3 < -17'sd30) dist_est = 16'd0;
		else begin
			shamt = 6'(17'sd32 - k_s3);
			rnd = (val_s3 + (41'd1 << (shamt - 6'd1))) >> shamt;
			dist_est = (rnd > 41'd65535) ? 16'hFFFF : rnd[15:0];
		end
	end

	// RAM address and write data.
	always_comb begin
		ram_we = 1'b0;
		ram_addr = ptr_q;
		ram_wdata = {addr_q, sig_q, now_q, name_q};
		if (state_q == S_IDLE) ram_addr = entry_sel;
		if (state_q == S_SEARCH && rd_pending_q && rd_addr == addr_q) begin
			ram_we = 1'b1;
			ram_addr = ptr_q - 5'd1;
			ram_wdata = {addr_q, sig_q, now_q, name_q | rd_named};
		end else if (state_q == S_SEARCH && ptr_q == count_q && !rd_pending_q) begin
			ram_we = count_q < 5'(TableDepth);
		end
	end

	// Only scan-mode adverts walk the table; a lock-mode advert compares with the target.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = (cmd == CMD_ADVERT && !lock_q) ? S_SEARCH : S_WAIT;
			S_SEARCH: begin
				if (rd_pending_q && rd_addr == addr_q) state_d = S_DIST1;
				else if (ptr_q == count_q && !rd_pending_q) state_d = S_DIST1;
			end
			S_WAIT: state_d = (cmd_q == CMD_TICK) ? S_EMA : S_DIST1;
			S_EMA: state_d = S_DIST1;
			S_DIST1: state_d = S_DIST2;
			S_DIST2: state_d = S_DIST3;
			S_DIST3: state_d = S_OUT;
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			alpha_q <= 9'd77;
			ref_q <= -8'sd59;
			scale_q <= 16'd9071;
			lock_q <= 1'b0;
			count_q <= '0;
			taddr_q <= '0;
			tdbm_q <= -8'sd100;
			smooth_q <= SMOOTH_RESET;
			done <= 1'b0;
			rd_pending_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == S_OUT);
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ALPHA: alpha_q <= cfg_data[8:0];
					REG_REF: ref_q <= cfg_data[7:0];
					REG_SCALE: scale_q <= cfg_data;
					default: ;
				endcase
			end
			rd_pending_q <= 1'b0;
			unique case (state_q)
				S_IDLE: ;
				S_SEARCH: begin
					if (rd_pending_q && rd_addr == addr_q) begin
					end else if (ptr_q == count_q && !rd_pending_q) begin
						if (count_q < 5'(TableDepth)) count_q <= count_q + 5'd1;
					end else begin
						rd_pending_q <= (ptr_q != count_q);
					end
				end
				S_WAIT: begin
					unique case (cmd_q)
						CMD_ADVERT: if (status_q == ST_LOCK_RSSI) tdbm_q <= sig_q;
						CMD_CLEAR: if (!lock_q) count_q <= '0;
						CMD_LOCK: if (status_q == ST_LOCKED) begin
							taddr_q <= rd_addr;
							tdbm_q <= rd_dbm;
							smooth_q <= 16'(rd_dbm) <<< 8;
							lock_q <= 1'b1;
						end
						CMD_RELEASE: if (lock_q) begin
							lock_q <= 1'b0;
							count_q <= '0;
							smooth_q <= SMOOTH_RESET;
						end
						default: ;
					endcase
				end
				S_EMA: if (lock_q) smooth_q <= 16'(ema_acc >>> 8);
				default: ;
			endcase
		end
	end

	// Command capture, search bookkeeping and result registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (start) begin
				cmd_q <= cmd;
				addr_q <= dev_addr;
				sig_q <= sig_dbm;
				name_q <= has_name;
				now_q <= now_ms;
				ptr_q <= '0;
				pos_q <= '0;
				entry_addr <= '0;
				entry_dbm <= '0;
				entry_seen_ms <= '0;
				entry_named <= 1'b0;
				status_q <= ST_IGNORED;
				unique case (cmd)
					CMD_ADVERT: if (lock_q && dev_addr == taddr_q) status_q <= ST_LOCK_RSSI;
					CMD_CLEAR: if (!lock_q) status_q <= ST_CLEARED;
					CMD_LOCK: begin
						if (!lock_q && entry_sel < count_q) begin
							status_q <= ST_LOCKED;
							pos_q <= entry_sel;
						end else status_q <= ST_LOCK_REJ;
					end
					CMD_RELEASE: if (lock_q) status_q <= ST_RELEASED;
					CMD_TICK: if (lock_q) status_q <= ST_FILTERED;
					CMD_READ: begin
						if (entry_sel < count_q) begin
							status_q <= ST_READ_OK;
							pos_q <= entry_sel;
						end else status_q <= ST_READ_OOR;
					end
					default: ;
				endcase
			end
			S_SEARCH: begin
				if (!lock_q) begin
					if (rd_pending_q && rd_addr == addr_q) begin
						status_q <= ST_UPDATED;
						pos_q <= ptr_q - 5'd1;
					end else if (ptr_q == count_q && !rd_pending_q) begin
						if (count_q < 5'(TableDepth)) begin
							status_q <= ST_ADDED;
							pos_q <= count_q;
						end else status_q <= ST_FULL;
					end else if (ptr_q != count_q) ptr_q <= ptr_q + 5'd1;
				end
			end
			S_WAIT: if (status_q == ST_READ_OK) begin
				entry_addr <= rd_addr;
				entry_dbm <= rd_dbm;
				entry_seen_ms <= rd_seen;
				entry_named <= rd_named;
			end
			default: ;
		endcase
		t_s1 <= 41'(diff) * $signed({1'b0, scale_q});
		ent_s2 <= EXP2_TAB[eidx];
		k_s2 <= kf;
		val_s3 <= 41'(ent_s2) * 41'd100;
		k_s3 <= k_s2;
		if (state_q == S_OUT) begin
			status <= status_q;
			mode_now <= lock_q;
			entry_count <= count_q;
			entry_pos <= pos_q;
			smooth_q8 <= smooth_q;
			distance_cm <= dist_est;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy);
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 5'(TableDepth))
		else $error("table count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n) ram_we |-> state_q == S_SEARCH)
		else $error("table written outside search");
endmodule
